// ===== hw/rtl/spmv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmv_pkg
// Shared types and constants of the sparse matrix times vector block.
// ----------------------------------------------------------------------------
package spmv_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int N_W        = DIM_W + 1;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * VALUE_BITS;
  localparam int ACC_W      = 64;
  localparam int OP_W       = 2;

  localparam logic [N_W-1:0] N_SIZE_RESET = N_W'(MAX_DIM);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

endpackage

// ===== hw/rtl/sparse_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// Streaming sparse matrix times dense vector in Q16.16 with a saturating
// 64-bit row accumulator and a saturated 32-bit row result.
//
//   Channel  Direction  Handshake          Word
//   in       input      in_valid/in_ready  op, col_index, value
//   out      output     out_valid/out_ready row_index, row_sum, last_row, index_error
//   cfg      input      cfg_wr_en          n_size
//
// One word is accepted per cycle while in_ready is high. A matrix entry reads
// the vector RAM at its accept edge, its product is registered in stage two,
// and it is then accumulated. A close word loads the result register from stage two.
// Reset clears the accumulator, row counter and error flag; the 1024-entry
// vector RAM is not cleared. A close word waits in front of the accumulator
// only while the result register is full and not taken.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply
  import spmv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [OP_W-1:0]              in_op,
  input  logic [DIM_W-1:0]             in_col_index,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DIM_W-1:0]             out_row_index,
  output logic signed [VALUE_BITS-1:0] out_row_sum,
  output logic                         out_last_row,
  output logic                         out_index_error,
  input  logic                         cfg_wr_en,
  input  logic [N_W-1:0]               cfg_wr_data
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] SUM_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] SUM_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam int HI_W = ACC_W - VALUE_BITS + 1;

  logic [N_W-1:0]  n_size_r;
  logic [N_W-1:0]  n_eff;
  logic            col_ok;
  logic            in_acc;
  logic            ram_we;
  logic            ram_re;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic                         s1_v_r;
  logic                         s1_mac_r;
  logic                         s1_err_r;
  logic                         s1_close_r;
  logic signed [VALUE_BITS-1:0] s1_val_r;

  logic                     s2_v_r;
  logic                     s2_mac_r;
  logic                     s2_err_r;
  logic                     s2_close_r;
  logic signed [PROD_W-1:0] s2_prod_r;

  logic s1_adv;
  logic s2_free;
  logic s2_fire;

  logic signed [ACC_W-1:0]      acc_r;
  logic [DIM_W-1:0]             row_cnt_r;
  logic                         row_err_r;
  logic signed [ACC_W-1:0]      prod_ext;
  logic signed [ACC_W:0]        acc_sum;
  logic signed [ACC_W-1:0]      acc_nxt;
  logic signed [ACC_W-1:0]      acc_shift;
  logic [HI_W-1:0]              acc_hi;
  logic signed [VALUE_BITS-1:0] sum_sat;
  logic [N_W-1:0]               n_last;
  logic                         at_last;

  logic                         out_valid_r;
  logic [DIM_W-1:0]             out_row_index_r;
  logic signed [VALUE_BITS-1:0] out_row_sum_r;
  logic                         out_last_row_r;
  logic                         out_index_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_size_r <= N_SIZE_RESET;
    end else if (cfg_wr_en) begin
      n_size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (n_size_r == '0) begin
      n_eff = N_W'(1);
    end else if (n_size_r > N_SIZE_RESET) begin
      n_eff = N_SIZE_RESET;
    end else begin
      n_eff = n_size_r;
    end
  end

  assign col_ok  = {1'b0, in_col_index} < n_eff;
  assign s2_fire = s2_v_r && (!s2_close_r || !out_valid_r || out_ready);
  assign s2_free = !s2_v_r || s2_fire;
  assign s1_adv  = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;
  assign in_acc  = in_valid && in_ready;
  assign ram_we  = in_acc && (in_op == OP_LOAD) && col_ok;
  assign ram_re  = in_acc && (in_op == OP_MAC) && col_ok;

  spmv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col_index),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (in_col_index),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_acc && ((in_op == OP_MAC) || (in_op == OP_CLOSE));
    end
    if (in_ready) begin
      s1_mac_r   <= (in_op == OP_MAC) && col_ok;
      s1_err_r   <= (in_op == OP_MAC) && !col_ok;
      s1_close_r <= (in_op == OP_CLOSE);
      s1_val_r   <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_free) begin
      s2_mac_r   <= s1_mac_r;
      s2_err_r   <= s1_err_r;
      s2_close_r <= s1_close_r;
      s2_prod_r  <= PROD_W'(s1_val_r) * PROD_W'($signed(ram_rdata));
    end
  end

  assign prod_ext = ACC_W'(s2_prod_r);
  assign acc_sum  = {acc_r[ACC_W-1], acc_r} + {prod_ext[ACC_W-1], prod_ext};

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  assign acc_shift = acc_r >>> FRAC_BITS;
  assign acc_hi    = acc_shift[ACC_W-1:VALUE_BITS-1];

  always_comb begin
    if ((acc_hi == '0) || (acc_hi == '1)) begin
      sum_sat = acc_shift[VALUE_BITS-1:0];
    end else begin
      sum_sat = acc_shift[ACC_W-1] ? SUM_MIN : SUM_MAX;
    end
  end

  assign n_last  = n_eff - N_W'(1);
  assign at_last = {1'b0, row_cnt_r} >= n_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      row_cnt_r   <= '0;
      row_err_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_fire && s2_mac_r) begin
        acc_r <= acc_nxt;
      end
      if (s2_fire && s2_err_r) begin
        row_err_r <= 1'b1;
      end
      if (s2_fire && s2_close_r) begin
        out_valid_r <= 1'b1;
        acc_r       <= '0;
        row_err_r   <= 1'b0;
        row_cnt_r   <= at_last ? '0 : row_cnt_r + DIM_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_close_r) begin
      out_row_index_r   <= row_cnt_r;
      out_row_sum_r     <= sum_sat;
      out_last_row_r    <= ({1'b0, row_cnt_r} == n_last);
      out_index_error_r <= row_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_index_r;
  assign out_row_sum     = out_row_sum_r;
  assign out_last_row    = out_last_row_r;
  assign out_index_error = out_index_error_r;

`ifndef SYNTHESIS
  a_ram_read_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (!s1_v_r || s1_adv))
    else $error("vector RAM read while stage one is held");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_fire) |=> (s2_v_r && s2_close_r && $stable(s2_prod_r)))
    else $error("stalled close word lost from stage two");

  a_acc_cleared_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_close_r) |=> (acc_r == '0 && !row_err_r))
    else $error("row state not cleared after a close");

  a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_fire && s2_close_r))
    else $error("result raised without a close word");
`endif

endmodule

// ===== hw/rtl/spmv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmv_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming sparse matrix times vector block.
// A short directed table covers the accumulator and result saturation, bad
// columns, ignored words, row counter wrap and the dimension register at its
// extremes. Random phases follow, each after a dimension write, made mostly of
// vector loads and well-formed rows with random content, plus some noise.
// Every row result is compared field by field against a bit-exact predictor.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import spmv_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_WORDS = 105;
  localparam logic signed [ACC_W-1:0] SUM_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SUM_LO = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [DIM_W-1:0]             row_index;
    logic signed [VALUE_BITS-1:0] row_sum;
    logic                         last_row;
    logic                         index_error;
  } row_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [N_W-1:0]        n_value;
    logic [OP_W-1:0]       op;
    logic [DIM_W-1:0]      col;
    logic [VALUE_BITS-1:0] value;
    bit                    fixed;
    row_result_t           res;
  } stim_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [OP_W-1:0]              in_op;
  logic [DIM_W-1:0]             in_col_index;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [DIM_W-1:0]             out_row_index;
  logic signed [VALUE_BITS-1:0] out_row_sum;
  logic                         out_last_row;
  logic                         out_index_error;
  logic                         cfg_wr_en;
  logic [N_W-1:0]               cfg_wr_data;

  sparse_matrix_vector_multiply i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_col_index   (in_col_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_row_sum    (out_row_sum),
    .out_last_row   (out_last_row),
    .out_index_error(out_index_error),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  logic signed [VALUE_BITS-1:0] vec_mem [MAX_DIM];
  logic signed [ACC_W-1:0]      row_acc;
  logic [DIM_W-1:0]             row_ctr;
  logic                         row_err;
  logic [N_W-1:0]               n_cfg;

  row_result_t          expected_rows [$];
  stim_row_t            directed_rows [$];
  logic [DIM_W-1:0]     phase_cols [$];
  int unsigned          idle_pct;
  int unsigned          cycle_count;
  bit                   mismatch_seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned dim_in_use();
    if (n_cfg == '0) return 1;
    if (n_cfg > N_W'(MAX_DIM)) return MAX_DIM;
    return 32'(n_cfg);
  endfunction

  function automatic bit predict_word(input logic [OP_W-1:0] op,
                                      input logic [DIM_W-1:0] col,
                                      input logic signed [VALUE_BITS-1:0] val,
                                      output row_result_t res);
    int unsigned n;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W:0] wide;
    logic signed [ACC_W-1:0] shifted;
    n = dim_in_use();
    res = '0;
    case (op)
      OP_LOAD: begin
        if (32'(col) < n) vec_mem[col] = val;
        return 1'b0;
      end
      OP_MAC: begin
        if (32'(col) >= n) begin
          row_err = 1'b1;
        end else begin
          prod = ACC_W'(vec_mem[col]) * ACC_W'(val);
          wide = {row_acc[ACC_W-1], row_acc} + {prod[ACC_W-1], prod};
          if (wide[ACC_W] != wide[ACC_W-1]) begin
            row_acc = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          end else begin
            row_acc = wide[ACC_W-1:0];
          end
        end
        return 1'b0;
      end
      OP_CLOSE: begin
        shifted = row_acc >>> FRAC_BITS;
        if (shifted > SUM_HI) shifted = SUM_HI;
        if (shifted < SUM_LO) shifted = SUM_LO;
        res.row_index = row_ctr;
        res.row_sum = shifted[VALUE_BITS-1:0];
        res.last_row = (row_ctr == DIM_W'(n - 1));
        res.index_error = row_err;
        row_acc = '0;
        row_err = 1'b0;
        if (32'(row_ctr) >= n - 1) row_ctr = '0;
        else row_ctr = row_ctr + DIM_W'(1);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [N_W-1:0] n_value);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.n_value = n_value;
    return r;
  endfunction

  function automatic stim_row_t word_row(input logic [OP_W-1:0] op,
                                         input logic [DIM_W-1:0] col,
                                         input logic [VALUE_BITS-1:0] value);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.col = col;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t fixed_close(input logic [DIM_W-1:0] row,
                                            input logic [VALUE_BITS-1:0] sum,
                                            input logic last, input logic err);
    stim_row_t r;
    r = word_row(OP_CLOSE, '0, '0);
    r.fixed = 1'b1;
    r.res.row_index = row;
    r.res.row_sum = sum;
    r.res.last_row = last;
    r.res.index_error = err;
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] rand_value();
    int unsigned sel;
    logic signed [VALUE_BITS-1:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel < 8) begin
      v = $urandom_range(0, 524288);
      return v - 262144;
    end
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [DIM_W-1:0] col,
                           input logic [VALUE_BITS-1:0] val, input bit use_fixed,
                           input row_result_t fixed_res);
    row_result_t res;
    bit produced;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_col_index <= col;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    produced = predict_word(op, col, val, res);
    if (produced) expected_rows.push_back(use_fixed ? fixed_res : res);
  endtask

  task automatic write_n_size(input logic [N_W-1:0] n_value);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n_value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_cfg = n_value;
  endtask

  task automatic load_random_col(input int unsigned n);
    logic [DIM_W-1:0] col;
    col = DIM_W'($urandom_range(0, n - 1));
    send_word(OP_LOAD, col, rand_value(), 1'b0, '0);
    phase_cols.push_back(col);
  endtask

  task automatic run_phase(input logic [N_W-1:0] n_value, input int unsigned words);
    int unsigned n;
    int unsigned count;
    int unsigned pick;
    int unsigned entries;
    logic [DIM_W-1:0] col;
    write_n_size(n_value);
    n = dim_in_use();
    phase_cols.delete();
    load_random_col(n);
    count = 1;
    while (count < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        load_random_col(n);
        count++;
      end else if (pick < 22) begin
        if (n < MAX_DIM && $urandom_range(0, 1) == 0) begin
          send_word(OP_LOAD, DIM_W'($urandom_range(n, MAX_DIM - 1)), rand_value(),
                    1'b0, '0);
        end else begin
          send_word(OP_UNUSED, DIM_W'($urandom()), $urandom(), 1'b0, '0);
        end
        count++;
      end else begin
        entries = $urandom_range(0, 6);
        repeat (entries) begin
          if (n < MAX_DIM && $urandom_range(0, 19) == 0) begin
            col = DIM_W'($urandom_range(n, MAX_DIM - 1));
          end else begin
            col = phase_cols[$urandom_range(0, phase_cols.size() - 1)];
          end
          send_word(OP_MAC, col, rand_value(), 1'b0, '0);
        end
        send_word(OP_CLOSE, DIM_W'($urandom()), $urandom(), 1'b0, '0);
        count += entries + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    row_result_t exp_row;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row result row_index=%0d row_sum=%h", $time,
                 out_row_index, out_row_sum);
        mismatch_seen = 1'b1;
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_row_index !== exp_row.row_index) begin
          $display("%0t: row_index expected %0d actual %0d", $time,
                   exp_row.row_index, out_row_index);
          mismatch_seen = 1'b1;
        end
        if (out_row_sum !== exp_row.row_sum) begin
          $display("%0t: row_sum expected %h actual %h", $time, exp_row.row_sum, out_row_sum);
          mismatch_seen = 1'b1;
        end
        if (out_last_row !== exp_row.last_row) begin
          $display("%0t: last_row expected %b actual %b", $time,
                   exp_row.last_row, out_last_row);
          mismatch_seen = 1'b1;
        end
        if (out_index_error !== exp_row.index_error) begin
          $display("%0t: index_error expected %b actual %b", $time,
                   exp_row.index_error, out_index_error);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [N_W-1:0] phase_dims [10];
    stim_row_t r;
    cycle_count = 0;
    mismatch_seen = 1'b0;
    idle_pct = 22;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_LOAD;
    in_col_index <= '0;
    in_value <= '0;
    out_ready <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    row_acc = '0;
    row_ctr = '0;
    row_err = 1'b0;
    n_cfg = N_SIZE_RESET;

    directed_rows.push_back(fixed_close(10'd0, 32'h0000_0000, 1'b0, 1'b0));
    directed_rows.push_back(word_row(OP_LOAD, 10'd0, 32'h7FFF_FFFF));
    directed_rows.push_back(word_row(OP_LOAD, 10'd1023, 32'h8000_0000));
    directed_rows.push_back(word_row(OP_LOAD, 10'd1, 32'h0001_0000));
    directed_rows.push_back(word_row(OP_MAC, 10'd1, 32'h0002_0000));
    directed_rows.push_back(word_row(OP_MAC, 10'd0, 32'hFFFF_0000));
    directed_rows.push_back(word_row(OP_CLOSE, 10'd0, 32'h0000_0000));
    directed_rows.push_back(word_row(OP_MAC, 10'd1023, 32'h8000_0000));
    directed_rows.push_back(word_row(OP_MAC, 10'd1023, 32'h8000_0000));
    directed_rows.push_back(fixed_close(10'd2, 32'h7FFF_FFFF, 1'b0, 1'b0));
    directed_rows.push_back(word_row(OP_MAC, 10'd1023, 32'h7FFF_FFFF));
    directed_rows.push_back(word_row(OP_MAC, 10'd1023, 32'h7FFF_FFFF));
    directed_rows.push_back(word_row(OP_MAC, 10'd1023, 32'h7FFF_FFFF));
    directed_rows.push_back(fixed_close(10'd3, 32'h8000_0000, 1'b0, 1'b0));
    directed_rows.push_back(word_row(OP_UNUSED, 10'd1023, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(11'd4));
    directed_rows.push_back(word_row(OP_CLOSE, 10'd0, 32'h0000_0000));
    directed_rows.push_back(word_row(OP_MAC, 10'd1023, 32'h0000_0001));
    directed_rows.push_back(fixed_close(10'd0, 32'h0000_0000, 1'b0, 1'b1));
    directed_rows.push_back(word_row(OP_LOAD, 10'd4, 32'h0000_0005));
    directed_rows.push_back(fixed_close(10'd1, 32'h0000_0000, 1'b0, 1'b0));
    directed_rows.push_back(fixed_close(10'd2, 32'h0000_0000, 1'b0, 1'b0));
    directed_rows.push_back(fixed_close(10'd3, 32'h0000_0000, 1'b1, 1'b0));
    directed_rows.push_back(cfg_row(11'd0));
    directed_rows.push_back(word_row(OP_MAC, 10'd1, 32'h0000_0001));
    directed_rows.push_back(fixed_close(10'd0, 32'h0000_0000, 1'b1, 1'b1));
    directed_rows.push_back(cfg_row(11'd2047));
    directed_rows.push_back(fixed_close(10'd0, 32'h0000_0000, 1'b0, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.is_cfg) write_n_size(r.n_value);
      else send_word(r.op, r.col, r.value, r.fixed, r.res);
    end

    phase_dims[0] = 11'd3;
    phase_dims[1] = 11'd1;
    phase_dims[2] = 11'd1024;
    phase_dims[3] = 11'd2;
    phase_dims[4] = 11'd2047;
    phase_dims[5] = 11'd0;
    phase_dims[6] = 11'd8;
    phase_dims[7] = N_W'($urandom_range(1, 2047));
    phase_dims[8] = 11'd5;
    phase_dims[9] = 11'd16;
    foreach (phase_dims[p]) begin
      idle_pct = (p == 3 || p == 4) ? 0 : 22;
      run_phase(phase_dims[p], PHASE_WORDS);
    end
    idle_pct = 22;

    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!mismatch_seen && expected_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
